// ===== src/amtab_pkg.sv =====
// ----------------------------------------------------------------------------
// AM modulator package
// Shared widths, register indexes, control commands and the sine table.
// ----------------------------------------------------------------------------
package amtab_pkg;

  localparam int TABLE_SIZE = 100;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int PHASE_W    = 18;
  localparam int BIAS_W     = 16;
  localparam int SAMPLE_W   = 16;
  localparam int SINE_W     = 16;
  localparam int NUM_W      = PHASE_W + IDX_W;
  localparam int BIASED_W   = BIAS_W + 2;
  localparam int PROD_W     = BIASED_W + SINE_W;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_ADDR_W-1:0] REG_CARRIER_FREQ = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_DC_BIAS      = 2'd2;

  localparam logic [PHASE_W-1:0] CARRIER_FREQ_RESET = 18'd6000;
  localparam logic [PHASE_W-1:0] SAMPLE_RATE_RESET  = 18'd48000;
  localparam logic [BIAS_W-1:0]  DC_BIAS_RESET      = 16'd32768;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;

  typedef struct packed {
    logic load;
    logic numer;
    logic div_step;
    logic lookup;
    logic mult;
    logic emit;
  } amtab_cmd_t;

  typedef logic signed [SINE_W-1:0] sine_table_t [TABLE_SIZE];

  // Q1.15 sine of i/TABLE_SIZE of a turn, by a truncating Taylor series.
  function automatic logic signed [SINE_W-1:0] sine_entry(input logic [31:0] i);
    logic [63:0]        turn;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic [63:0]        mag;
    logic [1:0]         quad;
    turn = (64'(i) << 32) / TABLE_SIZE;
    quad = turn[31:30];
    r    = turn & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    s    = signed'(x);
    term = ((x * x2) >> 30) / 6;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 20;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 42;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 72;
    s    = s + signed'(term);
    term = ((term * x2) >> 30) / 110;
    s    = s - signed'(term);
    term = ((term * x2) >> 30) / 156;
    s    = s + signed'(term);
    if (s < 0) begin
      s = 0;
    end
    mag = (unsigned'(s) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -signed'(mag[SINE_W-1:0]) : signed'(mag[SINE_W-1:0]);
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      t[i] = sine_entry(32'(i));
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== src/amtab_ctrl.sv =====
// ----------------------------------------------------------------------------
// AM modulator controller
// Sequences one sample through phase, scaling, divide, lookup, multiply and output.
// ----------------------------------------------------------------------------
module amtab_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output amtab_pkg::amtab_cmd_t cmd
);
  import amtab_pkg::*;

  localparam int CNT_W = $clog2(IDX_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_NUMER,
    S_DIVIDE,
    S_LOOKUP,
    S_MULT,
    S_EMIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cmd          = '0;
    cmd.load     = s_tvalid && s_tready;
    cmd.numer    = (state == S_NUMER);
    cmd.div_step = (state == S_DIVIDE);
    cmd.lookup   = (state == S_LOOKUP);
    cmd.mult     = (state == S_MULT);
    cmd.emit     = (state == S_EMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.load) begin
            s_tready <= 1'b0;
            state    <= S_NUMER;
          end
        end
        S_NUMER: begin
          cnt   <= CNT_W'(IDX_W - 1);
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          state <= S_MULT;
        end
        S_MULT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (cmd.emit) begin
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/amtab_datapath.sv =====
// ----------------------------------------------------------------------------
// AM modulator datapath
// Registers, phase accumulator, bit-serial index divider, sine lookup,
// multiplier and saturating output register.
// ----------------------------------------------------------------------------
module amtab_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  amtab_pkg::amtab_cmd_t                  cmd,
  input  logic signed [amtab_pkg::SAMPLE_W-1:0]  message_sample,
  output logic signed [amtab_pkg::SAMPLE_W-1:0]  am_sample,
  input  logic                                   cfg_wen,
  input  logic [amtab_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [amtab_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import amtab_pkg::*;

  logic [PHASE_W-1:0]         carrier_freq;
  logic [PHASE_W-1:0]         sample_rate;
  logic [BIAS_W-1:0]          dc_bias;
  logic [PHASE_W-1:0]         phase_acc;

  logic signed [SAMPLE_W-1:0] msg;
  logic [NUM_W-1:0]           rem;
  logic [NUM_W-1:0]           dsh;
  logic [IDX_W-1:0]           quot;
  logic                       ovf;
  logic signed [SINE_W-1:0]   sine_val;
  logic signed [BIASED_W-1:0] biased;
  logic signed [PROD_W-1:0]   prod;

  logic [PHASE_W:0]           sum_raw;
  logic [PHASE_W:0]           sum_wrap;
  logic [PHASE_W-1:0]         phase_next;
  logic [NUM_W-1:0]           numer;
  logic                       ge;
  logic [IDX_W-1:0]           idx;
  logic signed [PROD_W-1:0]   prod_adj;
  logic signed [PROD_W-17:0]  shifted;
  logic signed [SAMPLE_W-1:0] sat;

  always_comb begin
    sum_raw    = {1'b0, phase_acc} + {1'b0, carrier_freq};
    sum_wrap   = (sum_raw >= {1'b0, sample_rate}) ? sum_raw - {1'b0, sample_rate} : sum_raw;
    phase_next = sum_wrap[PHASE_W-1:0];
  end

  assign numer = NUM_W'(phase_acc) * NUM_W'(TABLE_SIZE);
  assign ge    = (rem >= dsh);

  always_comb begin
    if (ovf || ((IDX_W + 1)'(quot) >= (IDX_W + 1)'(TABLE_SIZE))) begin
      idx = IDX_W'(TABLE_SIZE - 1);
    end else begin
      idx = quot;
    end
  end

  always_comb begin
    prod_adj = prod + (prod[PROD_W-1] ? PROD_W'(16'hFFFF) : PROD_W'(0));
    shifted  = prod_adj[PROD_W-1:16];
    if (shifted > (PROD_W-16)'(32767)) begin
      sat = 16'sh7FFF;
    end else if (shifted < -(PROD_W-16)'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_freq <= CARRIER_FREQ_RESET;
      sample_rate  <= SAMPLE_RATE_RESET;
      dc_bias      <= DC_BIAS_RESET;
      phase_acc    <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_addr)
          REG_CARRIER_FREQ: carrier_freq <= cfg_wdata[PHASE_W-1:0];
          REG_SAMPLE_RATE:  sample_rate  <= cfg_wdata[PHASE_W-1:0];
          REG_DC_BIAS:      dc_bias      <= cfg_wdata[BIAS_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        phase_acc <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      msg <= message_sample;
    end
    if (cmd.numer) begin
      rem  <= numer;
      dsh  <= NUM_W'(sample_rate) << (IDX_W - 1);
      ovf  <= (numer >= (NUM_W'(sample_rate) << IDX_W));
      quot <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quot <= {quot[IDX_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
    if (cmd.lookup) begin
      sine_val <= SINE_TABLE[idx];
      biased   <= signed'({2'b00, dc_bias}) + BIASED_W'(msg);
    end
    if (cmd.mult) begin
      prod <= PROD_W'(biased) * PROD_W'(sine_val);
    end
    if (cmd.emit) begin
      am_sample <= sat;
    end
  end

endmodule

// ===== src/am_modulator_table_oscillator.sv =====
// ----------------------------------------------------------------------------
// AM modulator with table oscillator
// Multiplies each biased audio sample by a carrier taken from a sine table.
// ----------------------------------------------------------------------------
// Audio samples enter on the s_axis channel and modulated samples leave on
// the m_axis channel, one output beat for each input beat, in order. The
// cfg port writes the carrier frequency, the sample rate and the DC bias;
// it should only be used while no sample is in flight.
// A sample is processed in order: one phase update, one scaling step, one
// divider step per table index bit, then lookup, multiply and output. With
// the default table of 100 entries the index has IDX_W = 7 bits, and a new
// sample is taken only after the previous one reaches the output register.
// The bit-serial index divider is the longest part of this sequence.
// The finished sample waits in the output register while s_axis_tready is
// already high again; if the receiver still stalls when the next sample is
// done, that sample waits in the pipeline and no further input is taken.
// Reset clears the phase, restores the default registers and empties the
// output register.
// ----------------------------------------------------------------------------
module am_modulator_table_oscillator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [amtab_pkg::SAMPLE_W-1:0]        s_axis_tdata,  // [15:0] message_sample
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [amtab_pkg::SAMPLE_W-1:0]        m_axis_tdata,  // [15:0] am_sample
  input  logic                                  cfg_wen,
  input  logic [amtab_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [amtab_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import amtab_pkg::*;

  amtab_cmd_t                 cmd;
  logic signed [SAMPLE_W-1:0] am_sample;

  amtab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .m_tvalid (m_axis_tvalid),
    .m_tready (m_axis_tready),
    .cmd      (cmd)
  );

  amtab_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .message_sample (signed'(s_axis_tdata)),
    .am_sample      (am_sample),
    .cfg_wen        (cfg_wen),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  assign m_axis_tdata = unsigned'(am_sample);

endmodule
